// File: rtl/core/ilu_pkg.sv
// ----------------------------------------------------------------------------
// ilu_pkg
// Shared types, codes and saturation helpers of the ILU(0) grid solver.
// ----------------------------------------------------------------------------
package ilu_pkg;

  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 64;
  localparam int MAX_AW     = 20;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_RES  = 3'd1;
  localparam logic [2:0] CMD_FACT = 3'd2;
  localparam logic [2:0] CMD_CORR = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_FIN,
    ST_F_RD, ST_F_CAP, ST_F_CAP2, ST_F_DS1, ST_F_DW1, ST_F_DS2, ST_F_DW2, ST_F_WR,
    ST_C_RD, ST_C_CAP, ST_C_CAP2, ST_C_ACC, ST_C_DS, ST_C_DW,
    ST_B_RD, ST_B_CAP, ST_B_CAP2, ST_B_CAP3, ST_B_DS, ST_B_DW,
    ST_S_RD, ST_S_WR
  } seq_state_t;

  typedef struct packed {
    logic [MAX_AW-1:0] a_idx;
    logic [MAX_AW-1:0] a_e;
    logic [MAX_AW-1:0] a_n;
    logic [MAX_AW-1:0] a_piv;
    logic [MAX_AW-1:0] a_corr;
  } rd_t;

  typedef struct packed {
    logic [MAX_AW-1:0]  addr;
    logic               we_coef;
    logic               we_piv;
    logic               we_res;
    logic               we_sol;
    logic               we_corr;
    logic signed [31:0] cw;
    logic signed [31:0] cs;
    logic signed [31:0] cc;
    logic signed [31:0] cn;
    logic signed [31:0] ce;
    logic signed [31:0] data;
  } wr_t;

  typedef struct packed {
    logic signed [31:0] cw;
    logic signed [31:0] cs;
    logic signed [31:0] cc;
    logic signed [31:0] cn;
    logic signed [31:0] ce;
    logic signed [31:0] piv;
    logic signed [31:0] res;
    logic signed [31:0] sol;
    logic signed [31:0] corr;
  } rdata_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF)
      return 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000)
      return 32'sh8000_0000;
    else
      return v[31:0];
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
    if (v[64] != v[63])
      return v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      return v[63:0];
  endfunction

endpackage

// File: rtl/core/ilu_store.sv
// ----------------------------------------------------------------------------
// ilu_store
// Grid stores: five coefficients, pivot, residual, solution and correction.
// ----------------------------------------------------------------------------
module ilu_store import ilu_pkg::*; #(
  parameter int DEPTH = GRID_X_DEF * GRID_Y_DEF
) (
  input  logic   clk,
  input  rd_t    rd,
  input  wr_t    wr,
  output rdata_t rdo
);

  localparam int AW = $clog2(DEPTH);

  logic signed [31:0] m_cw   [DEPTH];
  logic signed [31:0] m_cs   [DEPTH];
  logic signed [31:0] m_cc   [DEPTH];
  logic signed [31:0] m_cn   [DEPTH];
  logic signed [31:0] m_ce   [DEPTH];
  logic signed [31:0] m_piv  [DEPTH];
  logic signed [31:0] m_res  [DEPTH];
  logic signed [31:0] m_sol  [DEPTH];
  logic signed [31:0] m_corr [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_coef) begin
      m_cw[wr.addr[AW-1:0]] <= wr.cw;
      m_cs[wr.addr[AW-1:0]] <= wr.cs;
      m_cc[wr.addr[AW-1:0]] <= wr.cc;
      m_cn[wr.addr[AW-1:0]] <= wr.cn;
      m_ce[wr.addr[AW-1:0]] <= wr.ce;
    end
    if (wr.we_piv)  m_piv[wr.addr[AW-1:0]]  <= wr.data;
    if (wr.we_res)  m_res[wr.addr[AW-1:0]]  <= wr.data;
    if (wr.we_sol)  m_sol[wr.addr[AW-1:0]]  <= wr.data;
    if (wr.we_corr) m_corr[wr.addr[AW-1:0]] <= wr.data;
  end

  always_ff @(posedge clk) begin
    rdo.cw   <= m_cw[rd.a_idx[AW-1:0]];
    rdo.cs   <= m_cs[rd.a_idx[AW-1:0]];
    rdo.cc   <= m_cc[rd.a_idx[AW-1:0]];
    rdo.cn   <= m_cn[rd.a_n[AW-1:0]];
    rdo.ce   <= m_ce[rd.a_e[AW-1:0]];
    rdo.piv  <= m_piv[rd.a_piv[AW-1:0]];
    rdo.res  <= m_res[rd.a_idx[AW-1:0]];
    rdo.sol  <= m_sol[rd.a_idx[AW-1:0]];
    rdo.corr <= m_corr[rd.a_corr[AW-1:0]];
  end

endmodule

// File: rtl/core/ilu_div.sv
// ----------------------------------------------------------------------------
// ilu_div
// Bit-serial signed divide, Q32.32 by Q16.16, truncating and saturating.
// ----------------------------------------------------------------------------
module ilu_div import ilu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo,
  output logic               zero
);

  localparam int STEPS = 64;
  localparam int SC_W  = $clog2(STEPS + 1);

  logic            run;
  logic            fin;
  logic [SC_W-1:0] cnt;
  logic [63:0]     nq;
  logic [31:0]     rem;
  logic [31:0]     dm;
  logic            neg;
  logic [32:0]     rem_sh;
  logic [32:0]     diff;
  logic            ge;

  assign rem_sh = {rem, nq[63]};
  assign diff   = rem_sh - {1'b0, dm};
  assign ge     = rem_sh >= {1'b0, dm};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          done <= 1'b1;
          quo  <= 32'sd0;
          zero <= 1'b1;
        end else begin
          run <= 1'b1;
          cnt <= SC_W'(STEPS);
          nq  <= num[63] ? 64'(-num) : 64'(num);
          dm  <= den[31] ? 32'(-den) : 32'(den);
          neg <= num[63] ^ den[31];
          rem <= 32'd0;
        end
      end else if (run) begin
        rem <= ge ? diff[31:0] : rem_sh[31:0];
        nq  <= {nq[62:0], ge};
        cnt <= cnt - SC_W'(1);
        if (cnt == SC_W'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        zero <= 1'b0;
        if (neg)
          quo <= (nq > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-nq[31:0]);
        else
          quo <= (nq > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : nq[31:0];
      end
    end
  end

endmodule

// File: rtl/core/ilu_five_point_grid_solver.sv
// ----------------------------------------------------------------------------
// ilu_five_point_grid_solver
// Modified ILU(0) preconditioner on a five-point stencil grid, Q16.16.
// ----------------------------------------------------------------------------
// Each command gives one result, strobed by done for one cycle; the receiver
// cannot stall it. Loads, out-of-range accesses and unused commands keep busy
// low and answer in the next cycle; a read goes through the registered
// solution store port and the ST_READ state. Factorize and correct sweep the
// interior one point at a time, with the bit-serial divider setting the pace
// (correct makes forward, backward and update passes). The correction store
// needs no clear: every sweep writes a point before any neighbour reads it.
module ilu_five_point_grid_solver import ilu_pkg::*; #(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           command,
  input  logic [5:0]           col,
  input  logic [5:0]           row,
  input  logic signed [31:0]   coef_west,
  input  logic signed [31:0]   coef_south,
  input  logic signed [31:0]   coef_center,
  input  logic signed [31:0]   coef_north,
  input  logic signed [31:0]   coef_east,
  input  logic signed [31:0]   value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output logic                 done,
  output logic [1:0]           status,
  output logic signed [31:0]   read_value
);

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] GXA = AW'(GRID_X);

  seq_state_t state, state_next;
  rd_t        rd;
  wr_t        wr;
  rdata_t     rdo;

  logic [CNT_W-1:0] grid_cols, grid_rows, eff_c, eff_r, last_i, last_j;
  logic [CNT_W-1:0] i, j;
  logic [AW-1:0]    idx, in_idx;
  logic             accept, in_range, empty, fwd_last, bwd_last;
  logic             zero_f;

  logic signed [31:0] c_center, c_s, c_n, c_e, piv0, piv1, t1, t2, cur;
  logic signed [63:0] pa, pb, acc;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] pv, bdata, sdata;

  logic               dv_start, dv_done, dv_zero;
  logic signed [63:0] dv_num;
  logic signed [31:0] dv_den, dv_q;

  ilu_store #(.DEPTH(DEPTH)) u_store (.clk(clk), .rd(rd), .wr(wr), .rdo(rdo));

  ilu_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_q), .zero(dv_zero)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  assign eff_c    = (int'(grid_cols) > GRID_X) ? CNT_W'(GRID_X) : grid_cols;
  assign eff_r    = (int'(grid_rows) > GRID_Y) ? CNT_W'(GRID_Y) : grid_rows;
  assign last_i   = eff_c - CNT_W'(2);
  assign last_j   = eff_r - CNT_W'(2);
  assign empty    = (eff_c < CNT_W'(3)) || (eff_r < CNT_W'(3));
  assign in_range = ({1'b0, col} < eff_c) && ({1'b0, row} < eff_r);
  assign fwd_last = (i == last_i) && (j == last_j);
  assign bwd_last = (i == CNT_W'(1)) && (j == CNT_W'(1));

  assign idx    = AW'(j) * GXA + AW'(i);
  assign in_idx = AW'(row) * GXA + AW'(col);

  assign prod  = mul_a * mul_b;
  assign pv    = sat32(66'(c_center) - 66'(t1) - 66'(t2));
  assign bdata = sat32(66'(cur) - 66'(dv_q));
  assign sdata = sat32(66'(rdo.sol) + 66'(rdo.corr));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= CNT_W'(64);
      grid_rows <= CNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COLS: grid_cols <= cfg_data;
        REG_ROWS: grid_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_READ && in_range) state_next = ST_READ;
          else if (command == CMD_FACT)        state_next = empty ? ST_FIN : ST_F_RD;
          else if (command == CMD_CORR)        state_next = empty ? ST_FIN : ST_C_RD;
        end
      end
      ST_READ:   state_next = ST_IDLE;
      ST_FIN:    state_next = ST_IDLE;
      ST_F_RD:   state_next = ST_F_CAP;
      ST_F_CAP:  state_next = ST_F_CAP2;
      ST_F_CAP2: state_next = ST_F_DS1;
      ST_F_DS1:  state_next = (i > CNT_W'(1)) ? ST_F_DW1 : ST_F_DS2;
      ST_F_DW1:  if (dv_done) state_next = ST_F_DS2;
      ST_F_DS2:  state_next = (j > CNT_W'(1)) ? ST_F_DW2 : ST_F_WR;
      ST_F_DW2:  if (dv_done) state_next = ST_F_WR;
      ST_F_WR:   state_next = fwd_last ? ST_FIN : ST_F_RD;
      ST_C_RD:   state_next = ST_C_CAP;
      ST_C_CAP:  state_next = ST_C_CAP2;
      ST_C_CAP2: state_next = ST_C_ACC;
      ST_C_ACC:  state_next = ST_C_DS;
      ST_C_DS:   state_next = ST_C_DW;
      ST_C_DW:   if (dv_done) state_next = fwd_last ? ST_B_RD : ST_C_RD;
      ST_B_RD:   state_next = ST_B_CAP;
      ST_B_CAP:  state_next = ST_B_CAP2;
      ST_B_CAP2: state_next = ST_B_CAP3;
      ST_B_CAP3: state_next = ST_B_DS;
      ST_B_DS:   state_next = ST_B_DW;
      ST_B_DW:   if (dv_done) state_next = bwd_last ? ST_S_RD : ST_B_RD;
      ST_S_RD:   state_next = ST_S_WR;
      ST_S_WR:   state_next = fwd_last ? ST_FIN : ST_S_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  // store, multiplier and divider control
  always_comb begin
    rd.a_idx  = MAX_AW'(idx);
    rd.a_e    = MAX_AW'(idx);
    rd.a_n    = MAX_AW'(idx);
    rd.a_piv  = MAX_AW'(idx);
    rd.a_corr = MAX_AW'(idx);
    wr.addr    = MAX_AW'(idx);
    wr.we_coef = 1'b0;
    wr.we_piv  = 1'b0;
    wr.we_res  = 1'b0;
    wr.we_sol  = 1'b0;
    wr.we_corr = 1'b0;
    wr.cw      = coef_west;
    wr.cs      = coef_south;
    wr.cc      = coef_center;
    wr.cn      = coef_north;
    wr.ce      = coef_east;
    wr.data    = value;
    mul_a    = rdo.cw;
    mul_b    = rdo.ce;
    dv_start = 1'b0;
    dv_num   = acc;
    dv_den   = piv0;
    unique case (state)
      ST_IDLE: begin
        rd.a_idx   = MAX_AW'(in_idx);
        wr.addr    = MAX_AW'(in_idx);
        wr.we_coef = accept && in_range && command == CMD_LOAD;
        wr.we_sol  = accept && in_range && command == CMD_LOAD;
        wr.we_res  = accept && in_range && command == CMD_RES;
      end
      ST_F_RD: begin
        rd.a_e   = MAX_AW'(idx - AW'(1));
        rd.a_piv = MAX_AW'(idx - AW'(1));
        rd.a_n   = MAX_AW'(idx - GXA);
      end
      ST_F_CAP: rd.a_piv = MAX_AW'(idx - GXA);
      ST_F_CAP2: begin
        mul_a = c_s;
        mul_b = c_n;
      end
      ST_F_DS1: begin
        dv_start = i > CNT_W'(1);
        dv_num   = pa;
      end
      ST_F_DS2: begin
        dv_start = j > CNT_W'(1);
        dv_num   = pb;
        dv_den   = piv1;
      end
      ST_F_WR: begin
        wr.we_piv = 1'b1;
        wr.data   = pv;
      end
      ST_C_RD: rd.a_corr = MAX_AW'(idx - AW'(1));
      ST_C_CAP: begin
        rd.a_corr = MAX_AW'(idx - GXA);
        mul_b     = (i > CNT_W'(1)) ? rdo.corr : 32'sd0;
      end
      ST_C_CAP2: begin
        mul_a = c_s;
        mul_b = (j > CNT_W'(1)) ? rdo.corr : 32'sd0;
      end
      ST_C_DS: dv_start = 1'b1;
      ST_C_DW: begin
        wr.we_corr = dv_done;
        wr.data    = dv_q;
      end
      ST_B_RD: rd.a_corr = MAX_AW'(idx + GXA);
      ST_B_CAP: begin
        rd.a_corr = MAX_AW'(idx + AW'(1));
        mul_a     = rdo.cn;
        mul_b     = (j < last_j) ? rdo.corr : 32'sd0;
      end
      ST_B_CAP2: begin
        mul_a = c_e;
        mul_b = (i < last_i) ? rdo.corr : 32'sd0;
      end
      ST_B_DS: dv_start = 1'b1;
      ST_B_DW: begin
        wr.we_corr = dv_done;
        wr.data    = bdata;
      end
      ST_S_WR: begin
        wr.we_sol = 1'b1;
        wr.data   = sdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      zero_f <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (dv_done) zero_f <= zero_f | dv_zero;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            read_value <= 32'sd0;
            status     <= STAT_OK;
            i          <= CNT_W'(1);
            j          <= CNT_W'(1);
            zero_f     <= 1'b0;
            if (command == CMD_LOAD || command == CMD_RES || command == CMD_READ) begin
              done   <= !(command == CMD_READ && in_range);
              status <= in_range ? STAT_OK : STAT_RANGE;
            end else if (command != CMD_FACT && command != CMD_CORR) begin
              done <= 1'b1;
            end
          end
        end
        ST_READ: begin
          done       <= 1'b1;
          status     <= STAT_OK;
          read_value <= rdo.sol;
        end
        ST_FIN: begin
          done       <= 1'b1;
          status     <= zero_f ? STAT_ZERO : STAT_OK;
          read_value <= 32'sd0;
        end
        ST_F_CAP: begin
          c_center <= rdo.cc;
          c_s      <= rdo.cs;
          c_n      <= rdo.cn;
          piv0     <= rdo.piv;
          pa       <= prod;
        end
        ST_F_CAP2: begin
          piv1 <= rdo.piv;
          pb   <= prod;
        end
        ST_F_DS1: if (i == CNT_W'(1)) t1 <= 32'sd0;
        ST_F_DW1: if (dv_done) t1 <= dv_q;
        ST_F_DS2: if (j == CNT_W'(1)) t2 <= 32'sd0;
        ST_F_DW2: if (dv_done) t2 <= dv_q;
        ST_F_WR: begin
          if (pv == 32'sd0) zero_f <= 1'b1;
          if (i == last_i) begin
            i <= CNT_W'(1);
            j <= j + CNT_W'(1);
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        ST_C_CAP: begin
          c_s  <= rdo.cs;
          piv0 <= rdo.piv;
          pa   <= prod;
          acc  <= -(64'(rdo.res) <<< 16);
        end
        ST_C_CAP2: begin
          pb  <= prod;
          acc <= sat64(65'(acc) - 65'(pa));
        end
        ST_C_ACC: acc <= sat64(65'(acc) - 65'(pb));
        ST_C_DW: begin
          if (dv_done) begin
            if (fwd_last) begin
              i <= last_i;
              j <= last_j;
            end else if (i == last_i) begin
              i <= CNT_W'(1);
              j <= j + CNT_W'(1);
            end else begin
              i <= i + CNT_W'(1);
            end
          end
        end
        ST_B_CAP: begin
          c_e  <= rdo.ce;
          piv0 <= rdo.piv;
          pa   <= prod;
        end
        ST_B_CAP2: pb <= prod;
        ST_B_CAP3: begin
          cur <= rdo.corr;
          acc <= sat64(65'(pa) + 65'(pb));
        end
        ST_B_DW: begin
          if (dv_done) begin
            if (bwd_last) begin
              i <= CNT_W'(1);
              j <= CNT_W'(1);
            end else if (i == CNT_W'(1)) begin
              i <= last_i;
              j <= j - CNT_W'(1);
            end else begin
              i <= i - CNT_W'(1);
            end
          end
        end
        ST_S_WR: begin
          if (i == last_i) begin
            i <= CNT_W'(1);
            j <= j + CNT_W'(1);
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: test/ilu_grid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ilu_grid_checker
// Watches the command, configuration and result ports of the ILU(0) grid
// solver, keeps its own copy of the grid stores and register settings,
// predicts status and read value for every accepted item and compares
// them in order with the strobed results.
// ----------------------------------------------------------------------------
module ilu_grid_checker import ilu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [2:0]           command,
  input  logic [5:0]           col,
  input  logic [5:0]           row,
  input  logic signed [31:0]   coef_west,
  input  logic signed [31:0]   coef_south,
  input  logic signed [31:0]   coef_center,
  input  logic signed [31:0]   coef_north,
  input  logic signed [31:0]   coef_east,
  input  logic signed [31:0]   value,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic                 done,
  input  logic [1:0]           status,
  input  logic signed [31:0]   read_value,
  output int                   fail_count,
  output int                   pending
);

  localparam int PITCH = GRID_X_DEF;
  localparam int CELLS = GRID_X_DEF * GRID_Y_DEF;
  localparam longint MIN64 = 64'sh8000_0000_0000_0000;
  localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         st;
    logic signed [31:0] rv;
  } grid_answer_t;

  int w_m[CELLS], s_m[CELLS], c_m[CELLS], n_m[CELLS], e_m[CELLS];
  int piv_m[CELLS], res_m[CELLS], sol_m[CELLS], corr_m[CELLS];
  int cols_reg, rows_reg;
  grid_answer_t answers[$];
  grid_answer_t front;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    if (b > 0 && a > MAX64 - b) return MAX64;
    if (b < 0 && a < MIN64 - b) return MIN64;
    return a + b;
  endfunction

  function automatic int quot(longint num, int d, inout bit zero);
    if (d == 0) begin
      zero = 1'b1;
      return 0;
    end
    if (d == -1) return (num == MIN64) ? 32'sh7FFF_FFFF : clip32(-num);
    return clip32(num / longint'(d));
  endfunction

  function automatic bit factor_grid(int nc, int nr);
    bit zero;
    int idx, ti, tj;
    zero = 1'b0;
    for (int j = 1; j <= nr - 2; j++)
      for (int i = 1; i <= nc - 2; i++) begin
        idx = j * PITCH + i;
        ti = 0;
        tj = 0;
        if (i > 1)
          ti = quot(longint'(w_m[idx]) * longint'(e_m[idx-1]), piv_m[idx-1], zero);
        if (j > 1)
          tj = quot(longint'(s_m[idx]) * longint'(n_m[idx-PITCH]), piv_m[idx-PITCH], zero);
        piv_m[idx] = clip32(longint'(c_m[idx]) - longint'(ti) - longint'(tj));
        if (piv_m[idx] == 0) zero = 1'b1;
      end
    return zero;
  endfunction

  function automatic bit correct_grid(int nc, int nr);
    bit zero;
    int idx, wv, sv, nv, ev, q;
    longint num;
    zero = 1'b0;
    for (int j = 1; j <= nr - 2; j++)
      for (int i = 1; i <= nc - 2; i++) begin
        idx = j * PITCH + i;
        wv = (i > 1) ? corr_m[idx-1] : 0;
        sv = (j > 1) ? corr_m[idx-PITCH] : 0;
        num = -longint'(res_m[idx]) * 64'sd65536;
        num = add_sat64(num, -(longint'(w_m[idx]) * longint'(wv)));
        num = add_sat64(num, -(longint'(s_m[idx]) * longint'(sv)));
        corr_m[idx] = quot(num, piv_m[idx], zero);
      end
    for (int j = nr - 2; j >= 1; j--)
      for (int i = nc - 2; i >= 1; i--) begin
        idx = j * PITCH + i;
        nv = (j < nr - 2) ? corr_m[idx+PITCH] : 0;
        ev = (i < nc - 2) ? corr_m[idx+1] : 0;
        num = add_sat64(longint'(n_m[idx]) * longint'(nv), longint'(e_m[idx]) * longint'(ev));
        q = quot(num, piv_m[idx], zero);
        corr_m[idx] = clip32(longint'(corr_m[idx]) - longint'(q));
      end
    for (int j = 1; j <= nr - 2; j++)
      for (int i = 1; i <= nc - 2; i++) begin
        idx = j * PITCH + i;
        sol_m[idx] = clip32(longint'(sol_m[idx]) + longint'(corr_m[idx]));
      end
    return zero;
  endfunction

  function automatic grid_answer_t solve_item();
    grid_answer_t a;
    int nc, nr, idx;
    a.st = STAT_OK;
    a.rv = '0;
    nc = (cols_reg > GRID_X_DEF) ? GRID_X_DEF : cols_reg;
    nr = (rows_reg > GRID_Y_DEF) ? GRID_Y_DEF : rows_reg;
    idx = int'(row) * PITCH + int'(col);
    case (command)
      CMD_LOAD, CMD_RES, CMD_READ: begin
        if (int'(col) >= nc || int'(row) >= nr)
          a.st = STAT_RANGE;
        else if (command == CMD_LOAD) begin
          w_m[idx] = coef_west;
          s_m[idx] = coef_south;
          c_m[idx] = coef_center;
          n_m[idx] = coef_north;
          e_m[idx] = coef_east;
          sol_m[idx] = value;
        end else if (command == CMD_RES)
          res_m[idx] = value;
        else
          a.rv = sol_m[idx];
      end
      CMD_FACT: if (factor_grid(nc, nr)) a.st = STAT_ZERO;
      CMD_CORR: if (correct_grid(nc, nr)) a.st = STAT_ZERO;
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      answers.delete();
      cols_reg = 64;
      rows_reg = 64;
      for (int k = 0; k < CELLS; k++) begin
        w_m[k] = 0; s_m[k] = 0; c_m[k] = 0; n_m[k] = 0; e_m[k] = 0;
        piv_m[k] = 0; res_m[k] = 0; sol_m[k] = 0; corr_m[k] = 0;
      end
    end else begin
      if (done) begin
        if (answers.size() == 0) begin
          $error("result strobed with no item outstanding");
          fail_count++;
        end else begin
          front = answers.pop_front();
          if (status !== front.st) begin
            $error("status: expected %0d, got %0d", front.st, status);
            fail_count++;
          end
          if (read_value !== front.rv) begin
            $error("read_value: expected %0d, got %0d", front.rv, read_value);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COLS: cols_reg = int'(cfg_data);
          REG_ROWS: rows_reg = int'(cfg_data);
          default: ;
        endcase
      end
      if (start && !busy) answers.push_back(solve_item());
    end
    pending = answers.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

// File: test/ilu_five_point_grid_solver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ilu_five_point_grid_solver_tb
// Drives commands and register writes into the ILU(0) grid solver over a
// range of grid sizes: directed corner cases first, then random loads, reads,
// factorize and correct sweeps with random gaps. Stores are only read once
// written. The checker instance predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module ilu_five_point_grid_solver_tb;
  import ilu_pkg::*;

  localparam int PITCH = GRID_X_DEF;
  localparam int CELLS = GRID_X_DEF * GRID_Y_DEF;
  localparam int QUIET_LIMIT = 60000;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int Q_ONE = 65536;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done;
  logic [2:0] command;
  logic [5:0] col, row;
  logic signed [31:0] coef_west, coef_south, coef_center, coef_north, coef_east, value;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0] cfg_data;
  logic [1:0] status;
  logic signed [31:0] read_value;
  int fail_count, pending, quiet;

  bit idle_en;
  int cols_now, rows_now;
  bit coef_ok[CELLS], res_ok[CELLS], sol_ok[CELLS], piv_ok[CELLS];

  ilu_five_point_grid_solver DUT (.*);

  ilu_grid_checker grid_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(logic [2:0] c, int i, int j, int w, int s, int ce, int n,
                      int e, int v);
    int idx;
    if (idle_en)
      while ($urandom_range(99) < 24) begin
        @(negedge clk);
        start <= 1'b0;
      end
    @(negedge clk);
    start <= 1'b1;
    command <= c;
    col <= 6'(i);
    row <= 6'(j);
    coef_west <= w;
    coef_south <= s;
    coef_center <= ce;
    coef_north <= n;
    coef_east <= e;
    value <= v;
    do @(posedge clk); while (busy);
    idx = j * PITCH + i;
    if (i < cols_now && j < rows_now) begin
      if (c == CMD_LOAD) begin
        coef_ok[idx] = 1'b1;
        sol_ok[idx] = 1'b1;
      end else if (c == CMD_RES)
        res_ok[idx] = 1'b1;
    end
    if (c == CMD_FACT)
      for (int jj = 1; jj <= rows_now - 2; jj++)
        for (int ii = 1; ii <= cols_now - 2; ii++) piv_ok[jj*PITCH+ii] = 1'b1;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    if (idle_en)
      while ($urandom_range(99) < 24) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CNT_W'(data);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_COLS) cols_now = data;
    else rows_now = data;
  endtask

  function automatic int odd_word();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int jitter(int base, int span);
    return base + int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic load_point(int i, int j, bit noisy);
    if (noisy)
      send(CMD_LOAD, i, j, odd_word(), odd_word(), odd_word(), odd_word(), odd_word(),
           odd_word());
    else
      send(CMD_LOAD, i, j, jitter(-Q_ONE, 4096), jitter(-Q_ONE, 4096),
           jitter(4 * Q_ONE, 8192), jitter(-Q_ONE, 4096), jitter(-Q_ONE, 4096),
           jitter(0, 1 << 20));
  endtask

  task automatic load_residual(int i, int j, bit noisy);
    send(CMD_RES, i, j, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
         int'($urandom), noisy ? odd_word() : jitter(0, 1 << 18));
  endtask

  function automatic bit grid_ready(bit need_all);
    int idx;
    for (int j = 1; j <= rows_now - 2; j++)
      for (int i = 1; i <= cols_now - 2; i++) begin
        idx = j * PITCH + i;
        if (!coef_ok[idx]) return 1'b0;
        if (need_all && !(res_ok[idx] && sol_ok[idx] && piv_ok[idx])) return 1'b0;
      end
    return 1'b1;
  endfunction

  task automatic random_item(bit sweeps);
    int k, i, j, cells;
    bit noisy, sweep_ok;
    k = $urandom_range(99);
    noisy = $urandom_range(9) < 3;
    if ($urandom_range(3) == 0) begin
      i = $urandom_range(63);
      j = $urandom_range(63);
    end else begin
      i = $urandom_range(cols_now - 1);
      j = $urandom_range(rows_now - 1);
    end
    cells = (cols_now - 2) * (rows_now - 2);
    sweep_ok = sweeps && (cells <= 40 || $urandom_range(9) == 0);
    if (k < 35)
      load_point(i, j, noisy);
    else if (k < 55)
      load_residual(i, j, noisy);
    else if (k < 80) begin
      if (i < cols_now && j < rows_now && !sol_ok[j*PITCH+i])
        load_point(i, j, noisy);
      else
        send(CMD_READ, i, j, odd_word(), odd_word(), odd_word(), odd_word(),
             odd_word(), odd_word());
    end else if (k < 86 && sweep_ok && grid_ready(1'b0))
      send(CMD_FACT, $urandom_range(63), $urandom_range(63), odd_word(), odd_word(),
           odd_word(), odd_word(), odd_word(), odd_word());
    else if (k < 93 && sweep_ok && grid_ready(1'b1))
      send(CMD_CORR, $urandom_range(63), $urandom_range(63), odd_word(), odd_word(),
           odd_word(), odd_word(), odd_word(), odd_word());
    else if (k < 96)
      send(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), i, j, odd_word(),
           odd_word(), odd_word(), odd_word(), odd_word(), odd_word());
    else
      load_point(i, j, noisy);
  endtask

  task automatic run_phase(int c, int r, int n_items, bit sweeps);
    int idx;
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, r);
    if (sweeps) begin
      for (int j = 1; j <= rows_now - 2; j++)
        for (int i = 1; i <= cols_now - 2; i++) begin
          idx = j * PITCH + i;
          if (!coef_ok[idx] || !sol_ok[idx]) load_point(i, j, $urandom_range(9) == 0);
          if (!res_ok[idx]) load_residual(i, j, $urandom_range(9) == 0);
        end
      send(CMD_FACT, 0, 0, 0, 0, 0, 0, 0, 0);
    end
    repeat (n_items) random_item(sweeps);
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= QUIET_LIMIT) begin
      $display("ilu_five_point_grid_solver verification failed");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_LOAD;
    col = '0;
    row = '0;
    coef_west = '0;
    coef_south = '0;
    coef_center = '0;
    coef_north = '0;
    coef_east = '0;
    value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COLS;
    cfg_data = '0;
    quiet = 0;
    idle_en = 1'b1;
    cols_now = 64;
    rows_now = 64;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero pivots across the whole interior, sweeps with junk coordinates
    write_reg(REG_COLS, 5);
    write_reg(REG_ROWS, 4);
    for (int j = 1; j <= 2; j++)
      for (int i = 1; i <= 3; i++) begin
        send(CMD_LOAD, i, j, 0, 0, 0, 0, 0, 0);
        send(CMD_RES, i, j, 0, 0, 0, 0, 0, jitter(0, 1 << 16));
      end
    send(CMD_FACT, 63, 63, -1, -1, -1, -1, -1, -1);
    send(CMD_CORR, 63, 0, -1, -1, -1, -1, -1, -1);
    send(CMD_LOAD, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
         32'sh7FFF_FFFF, -1, 32'sh7FFF_FFFF);
    send(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_READ, 2, 1, 0, 0, 0, 0, 0, 0);
    send(CMD_LOAD, 5, 0, 1, 1, 1, 1, 1, 1);
    send(CMD_RES, 0, 4, 0, 0, 0, 0, 0, 32'sh8000_0000);
    send(CMD_READ, 63, 63, 0, 0, 0, 0, 0, 0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      send(3'(c), 63, 63, -1, -1, -1, -1, -1, -1);

    run_phase(3, 3, 100, 1'b1);
    run_phase(64, 3, 110, 1'b1);
    run_phase(3, 64, 110, 1'b1);
    run_phase(64, 64, 100, 1'b0);
    for (int p = 0; p < 8; p++) begin
      idle_en = (p != 2);
      run_phase($urandom_range(3, 9), $urandom_range(3, 9), 100, 1'b1);
    end
    idle_en = 1'b1;

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("ilu_five_point_grid_solver verification clean");
    else
      $display("ilu_five_point_grid_solver verification failed");
    $finish;
  end

endmodule
